>>> hw/rtl/thermistor_average_peak_hold_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the thermistor average / peak hold core
// Clocked, reset-qualified wrappers for same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_AVERAGE_PEAK_HOLD_CORE_MACROS_SVH
`define THERMISTOR_AVERAGE_PEAK_HOLD_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define TAPH_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TAPH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/taph_pkg.sv
// ----------------------------------------------------------------------------
// taph_pkg
// Types and constants shared by the thermistor average / peak hold core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package taph_pkg;

  // Block lengths in samples
  localparam int INSTANT_BLOCK = 512;
  localparam int PEAK_BLOCK    = 64;

  // Field and state widths
  localparam int SampleW = 10;
  localparam int CntW    = 10;
  localparam int SumW    = 19;
  localparam int AgeW    = 6;
  localparam int TempW   = 16;
  localparam int CfgIdxW = 1;

  // Conversion constants
  localparam int VREF_SCALE  = 320;
  localparam int RECU        = 2342;
  localparam int VIN_Q18     = 1310720;
  localparam int ZERO_OFFSET = 456;
  localparam int SLOPE_Q16   = 106168;
  localparam int HOLD_DELTA  = 5;

  // Peak age limits in quarter-second ticks
  localparam int SHORT_AGE = 4 * 5;
  localparam int LONG_AGE  = 4 * 10;

  // Scaled sum: sum * 320 stays below 2^(SumW + 9)
  localparam int ProdW = SumW + 9;

  // Right shift of the scaled sum: floor(log2(block)) - 2
  localparam int InstShift = $clog2(INSTANT_BLOCK + 1) - 1 - 2;
  localparam int PeakShift = $clog2(PEAK_BLOCK + 1) - 1 - 2;

  // Shared restoring divider
  localparam int DivW    = 32;
  localparam int DivCntW = $clog2(DivW);

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_TICK    = 2'd1,
    OP_DISPLAY = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FAHRENHEIT = 1'b0,
    CFG_LONG_HOLD  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_PRODUCT,
    ST_DIV_REC,
    ST_PREP_TEMP,
    ST_DIV_TEMP,
    ST_FINISH,
    ST_OUTPUT
  } state_e;

endpackage

`default_nettype wire

>>> hw/rtl/thermistor_average_peak_hold_core.sv
// Thermistor block average with peak hold. ADC samples (operation 0) and
// peak age ticks (operation 1) complete in the cycle they transfer and the
// core is ready again on the next cycle. A display request (operation 2)
// whose mode matches the stored mode starts a conversion, which runs a
// single 32-step restoring divider twice (resistance, then degrees). A
// peak reading with a held peak converts twice, the current block and
// then the peak. The core is not ready while a conversion runs. The result
// sits in an output register, so samples and ticks keep transferring
// while a reading waits to be taken. A display request with a different
// mode switches mode and gives no reading.
// ----------------------------------------------------------------------------
// thermistor_average_peak_hold_core
// Block averaging, peak hold and iterative conversion to degrees C.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thermistor_average_peak_hold_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [taph_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic                          cfg_data_i,
  // Input channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    operation_i,
  input  wire logic [taph_pkg::SampleW-1:0]  sample_i,
  input  wire logic                          display_mode_i,
  // Output channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [taph_pkg::TempW-1:0]  temp_c_o,
  output logic                               peak_hold_o,
  output logic                               fahrenheit_o,
  output logic                               shown_mode_o
);

  import taph_pkg::*;

  // Configuration
  logic fahr_q, long_q;

  // Architectural state
  logic [SumW-1:0] run_q, run_d;
  logic [SumW-1:0] blk_q, blk_d;
  logic [SumW-1:0] pk_q, pk_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AgeW-1:0] age_q, age_d;
  logic            held_q, held_d;
  logic            mode_q, mode_d;

  // Sequencer
  state_e state_q, state_d;
  logic   in_xfer;
  logic   start_conv;
  logic   load_v, load_num, div_step, load_temp, finish, out_load;

  // Conversion datapath
  logic                   want_peak_q, src_sel_q;
  logic [ProdW-1:0]       prod, v_d, v_q;
  logic [DivW-1:0]        num, den;
  logic [DivW-1:0]        div_rem_q, div_quo_q, div_dvs_q;
  logic [DivCntW-1:0]     div_cnt_q;
  logic [DivW:0]          div_shift;
  logic                   div_ge;
  logic [DivW-1:0]        div_rem_nxt;
  logic                   div_last;
  logic [TempW-1:0]       r16, d16, mag16, q16, t16;
  logic                   neg_q;
  logic signed [TempW-1:0] cur_temp_q, pk_temp_q;
  logic signed [TempW:0]  gap;

  // Sample bookkeeping
  logic [CntW-1:0] blk_len, cnt_base, cnt_next;
  logic [AgeW-1:0] age_lim;
  logic [SumW-1:0] run_sum;

  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign start_conv  = in_xfer && (operation_i == OP_DISPLAY) && (display_mode_i == mode_q);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fahr_q <= 1'b0;
      long_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_FAHRENHEIT) begin
        fahr_q <= cfg_data_i;
      end else begin
        long_q <= cfg_data_i;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Samples, ticks and mode switches
  // --------------------------------------------------------------------------
  assign blk_len  = mode_q ? CntW'(PEAK_BLOCK) : CntW'(INSTANT_BLOCK);
  assign age_lim  = long_q ? AgeW'(LONG_AGE) : AgeW'(SHORT_AGE);
  assign cnt_base = (cnt_q > blk_len) ? '0 : cnt_q;
  assign cnt_next = cnt_base + CntW'(1);
  assign run_sum  = run_q + SumW'(sample_i);

  always_comb begin
    run_d  = run_q;
    blk_d  = blk_q;
    pk_d   = pk_q;
    cnt_d  = cnt_q;
    age_d  = age_q;
    held_d = held_q;
    mode_d = mode_q;
    if (in_xfer) begin
      unique case (operation_i)
        OP_SAMPLE: begin
          if (cnt_next == blk_len) begin
            cnt_d = '0;
            run_d = '0;
            blk_d = run_sum;
            if ((run_sum > pk_q) || (age_q >= age_lim) || !held_q) begin
              held_d = 1'b1;
              pk_d   = run_sum;
              age_d  = '0;
            end
          end else begin
            cnt_d = cnt_next;
            run_d = run_sum;
          end
        end
        OP_TICK: begin
          if (age_q < age_lim) begin
            age_d = age_q + AgeW'(1);
          end
        end
        OP_DISPLAY: begin
          // Switch mode, restart accumulation and drop the held peak
          if (display_mode_i != mode_q) begin
            mode_d = display_mode_i;
            cnt_d  = '0;
            run_d  = '0;
            held_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      blk_q  <= '0;
      pk_q   <= '0;
      cnt_q  <= '0;
      age_q  <= '0;
      held_q <= 1'b0;
      mode_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      blk_q  <= blk_d;
      pk_q   <= pk_d;
      cnt_q  <= cnt_d;
      age_q  <= age_d;
      held_q <= held_d;
      mode_q <= mode_d;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign div_last = (div_cnt_q == DivCntW'(DivW - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (start_conv) state_d = ST_SCALE;
      ST_SCALE:     state_d = ST_PRODUCT;
      ST_PRODUCT:   state_d = ST_DIV_REC;
      ST_DIV_REC:   if (div_last) state_d = ST_PREP_TEMP;
      ST_PREP_TEMP: state_d = ST_DIV_TEMP;
      ST_DIV_TEMP:  if (div_last) state_d = ST_FINISH;
      ST_FINISH: begin
        // Convert the peak after the current reading when one is shown
        if (!src_sel_q && want_peak_q) begin
          state_d = ST_SCALE;
        end else begin
          state_d = ST_OUTPUT;
        end
      end
      ST_OUTPUT:    if (!out_valid_o || out_ready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    load_v     = (state_q == ST_SCALE);
    load_num   = (state_q == ST_PRODUCT);
    div_step   = (state_q == ST_DIV_REC) || (state_q == ST_DIV_TEMP);
    load_temp  = (state_q == ST_PREP_TEMP);
    finish     = (state_q == ST_FINISH);
    out_load   = (state_q == ST_OUTPUT) && (!out_valid_o || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Conversion datapath
  // --------------------------------------------------------------------------
  assign prod = ProdW'(src_sel_q ? pk_q : blk_q) * ProdW'(VREF_SCALE);
  assign v_d  = mode_q ? (prod >> PeakShift) : (prod >> InstShift);
  assign num  = DivW'(v_q) * DivW'(RECU);
  assign den  = DivW'(VIN_Q18) - DivW'(v_q);

  // One restoring step: a zero divisor yields an all-ones quotient
  assign div_shift   = {div_rem_q, div_quo_q[DivW-1]};
  assign div_ge      = (div_shift >= {1'b0, div_dvs_q});
  assign div_rem_nxt = div_ge ? DivW'(div_shift - {1'b0, div_dvs_q}) : DivW'(div_shift);

  assign r16   = div_quo_q[TempW-1:0];
  assign d16   = r16 - TempW'(ZERO_OFFSET);
  assign mag16 = d16[TempW-1] ? (TempW'(0) - d16) : d16;
  assign q16   = div_quo_q[TempW-1:0];
  assign t16   = neg_q ? (TempW'(0) - q16) : q16;

  assign gap = {pk_temp_q[TempW-1], pk_temp_q} - {cur_temp_q[TempW-1], cur_temp_q};

  always_ff @(posedge clk_i) begin
    if (start_conv) begin
      want_peak_q <= display_mode_i && held_q;
      src_sel_q   <= 1'b0;
    end
    if (load_v) begin
      v_q <= v_d;
    end
    if (load_num) begin
      div_rem_q <= '0;
      div_quo_q <= num;
      div_dvs_q <= den;
      div_cnt_q <= '0;
    end else if (load_temp) begin
      // Magnitude of ((r - 456) << 16); its low half is zero
      div_rem_q <= '0;
      div_quo_q <= {mag16, TempW'(0)};
      div_dvs_q <= DivW'(SLOPE_Q16);
      div_cnt_q <= '0;
      neg_q     <= d16[TempW-1];
    end else if (div_step) begin
      div_rem_q <= div_rem_nxt;
      div_quo_q <= {div_quo_q[DivW-2:0], div_ge};
      div_cnt_q <= div_cnt_q + DivCntW'(1);
    end
    if (finish) begin
      if (src_sel_q) begin
        pk_temp_q <= t16;
      end else begin
        cur_temp_q <= t16;
        src_sel_q  <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      temp_c_o     <= want_peak_q ? pk_temp_q : cur_temp_q;
      peak_hold_o  <= want_peak_q && (gap >= (TempW + 1)'(HOLD_DELTA));
      fahrenheit_o <= fahr_q;
      shown_mode_o <= mode_q;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/taph_checker.sv
// ----------------------------------------------------------------------------
// taph_checker
// Port-level checks for the thermistor average / peak hold core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "thermistor_average_peak_hold_core_macros.svh"

module taph_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic [1:0]                    operation_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic signed [taph_pkg::TempW-1:0] temp_c_o,
  input wire logic                          peak_hold_o,
  input wire logic                          fahrenheit_o,
  input wire logic                          shown_mode_o
);

  import taph_pkg::*;

  // Hold a stalled result
  `TAPH_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(temp_c_o) && $stable(peak_hold_o) && $stable(fahrenheit_o) && $stable(shown_mode_o), "stalled result changed")

  // Samples and ticks finish in the cycle of their transfer
  `TAPH_ASSERT_NEXT(a_quick_ops, in_valid_i && in_ready_o && (operation_i != OP_DISPLAY), in_ready_o, "sample or tick kept the core busy")

  // A conversion never finishes on the cycle after its request
  `TAPH_ASSERT_NEXT(a_no_instant_result, in_valid_i && in_ready_o && (operation_i == OP_DISPLAY), !$rose(out_valid_o), "result appeared too early")

  // Peak hold only shows in peak mode
  `TAPH_ASSERT(a_hold_peak_only, out_valid_o && !shown_mode_o, !peak_hold_o, "peak hold flag in instant mode")

endmodule

bind thermistor_average_peak_hold_core taph_checker u_taph_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .operation_i  (operation_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .temp_c_o     (temp_c_o),
  .peak_hold_o  (peak_hold_o),
  .fahrenheit_o (fahrenheit_o),
  .shown_mode_o (shown_mode_o)
);

`default_nettype wire

>>> test/temp_reading_checker.sv
// ----------------------------------------------------------------------------
// temp_reading_checker
// Tracks block sums, peak and mode from every transfer into the core, works
// out each temperature reading it owes and compares the readings it gives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module temp_reading_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [taph_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic                               cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [1:0]                         operation_i,
  input  logic [taph_pkg::SampleW-1:0]       sample_i,
  input  logic                               display_mode_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [taph_pkg::TempW-1:0]  temp_c_i,
  input  logic                               peak_hold_i,
  input  logic                               fahrenheit_i,
  input  logic                               shown_mode_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 checked_o
);
  import taph_pkg::*;

  localparam int InstLen    = 512;
  localparam int PeakLen    = 64;
  localparam int InstShr    = 7;
  localparam int PeakShr    = 4;
  localparam int ShortLimit = 20;
  localparam int LongLimit  = 40;
  localparam int HoldMargin = 5;
  localparam logic [31:0] Scale320  = 32'd320;
  localparam logic [31:0] RecuGain  = 32'd2342;
  localparam logic [31:0] VinFull   = 32'd1310720;
  localparam logic [31:0] OffsetRaw = 32'd456;
  localparam int          DegSlope  = 106168;

  typedef struct packed {
    logic signed [15:0] temp_c;
    logic               peak_hold;
    logic               fahrenheit;
    logic               shown_mode;
  } reading_t;

  logic [18:0] acc_sum     = '0;
  logic [18:0] block_sum   = '0;
  logic [18:0] peak_sum    = '0;
  logic [9:0]  acc_count   = '0;
  logic [5:0]  peak_age    = '0;
  logic        have_peak   = 1'b0;
  logic        disp_mode   = 1'b0;
  logic        fahr_cfg    = 1'b0;
  logic        long_cfg    = 1'b0;
  reading_t    readings_due[$];
  int          fails       = 0;
  int          checked     = 0;

  function automatic int age_limit();
    return long_cfg ? LongLimit : ShortLimit;
  endfunction

  // Fixed-width conversion: scale, divide for resistance, divide for degrees.
  function automatic logic signed [15:0] to_degrees(logic [18:0] sum, int unsigned shr);
    logic [31:0] volts;
    logic [31:0] num;
    logic [31:0] den;
    logic [31:0] quot;
    logic [31:0] scaled;
    int          deg;
    volts  = ({13'd0, sum} * Scale320) >> shr;
    num    = volts * RecuGain;
    den    = VinFull - volts;
    // a zero divisor returns all ones, as a restoring divider does
    quot   = (den == '0) ? '1 : num / den;
    scaled = ({16'd0, quot[15:0]} - OffsetRaw) << 16;
    deg    = $signed(scaled) / DegSlope;
    return deg[15:0];
  endfunction

  task automatic predict_item(logic [1:0] op, logic [9:0] smp, logic mode);
    int                 blk;
    int unsigned        shr;
    logic signed [15:0] now_c;
    logic signed [15:0] peak_c;
    reading_t           rd;
    blk = disp_mode ? PeakLen : InstLen;
    case (op)
      OP_SAMPLE: begin
        if (acc_count > blk) acc_count = '0;
        acc_sum   = acc_sum + smp;
        acc_count = acc_count + 1'b1;
        if (acc_count == blk) begin
          acc_count = '0;
          block_sum = acc_sum;
          acc_sum   = '0;
          if (block_sum > peak_sum || peak_age >= age_limit() || !have_peak) begin
            have_peak = 1'b1;
            peak_sum  = block_sum;
            peak_age  = '0;
          end
        end
      end
      OP_TICK: begin
        if (peak_age < age_limit()) peak_age = peak_age + 1'b1;
      end
      OP_DISPLAY: begin
        if (mode != disp_mode) begin
          // switch mode: drop the partial block and the peak, no reading
          disp_mode = mode;
          acc_count = '0;
          acc_sum   = '0;
          have_peak = 1'b0;
        end else begin
          shr          = disp_mode ? PeakShr : InstShr;
          now_c        = to_degrees(block_sum, shr);
          rd.temp_c    = now_c;
          rd.peak_hold = 1'b0;
          if (mode && have_peak) begin
            peak_c = to_degrees(peak_sum, shr);
            if (int'(peak_c) - int'(now_c) >= HoldMargin) rd.peak_hold = 1'b1;
            rd.temp_c = peak_c;
          end
          rd.fahrenheit = fahr_cfg;
          rd.shown_mode = mode;
          readings_due.push_back(rd);
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reading_t got;
    reading_t want;
    if (!rst_ni) begin
      acc_sum   = '0;
      block_sum = '0;
      peak_sum  = '0;
      acc_count = '0;
      peak_age  = '0;
      have_peak = 1'b0;
      disp_mode = 1'b0;
      fahr_cfg  = 1'b0;
      long_cfg  = 1'b0;
      readings_due.delete();
      fail_count_o <= fails;
      pending_o    <= 0;
      checked_o    <= checked;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FAHRENHEIT: fahr_cfg = cfg_data_i;
          CFG_LONG_HOLD:  long_cfg = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got.temp_c     = temp_c_i;
        got.peak_hold  = peak_hold_i;
        got.fahrenheit = fahrenheit_i;
        got.shown_mode = shown_mode_i;
        if (readings_due.size() == 0) begin
          $error("reading transfer with none expected: temp_c %0d", got.temp_c);
          fails++;
        end else begin
          want = readings_due.pop_front();
          checked++;
          if (got.temp_c !== want.temp_c) begin
            $error("temp_c mismatch: expected %0d, actual %0d", want.temp_c, got.temp_c);
            fails++;
          end
          if (got.peak_hold !== want.peak_hold) begin
            $error("peak_hold mismatch: expected %0b, actual %0b",
                   want.peak_hold, got.peak_hold);
            fails++;
          end
          if (got.fahrenheit !== want.fahrenheit) begin
            $error("fahrenheit mismatch: expected %0b, actual %0b",
                   want.fahrenheit, got.fahrenheit);
            fails++;
          end
          if (got.shown_mode !== want.shown_mode) begin
            $error("shown_mode mismatch: expected %0b, actual %0b",
                   want.shown_mode, got.shown_mode);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_item(operation_i, sample_i, display_mode_i);
      fail_count_o <= fails;
      pending_o    <= readings_due.size();
      checked_o    <= checked;
    end
  end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives samples, ticks and display requests into the thermistor core with
// random idling on both sides, walks through the unit and hold settings and
// reports the verdict from the reading checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import taph_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;

  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       cfg_valid_i    = 1'b0;
  logic [CfgIdxW-1:0]         cfg_index_i    = '0;
  logic                       cfg_data_i     = 1'b0;
  logic                       in_valid_i     = 1'b0;
  logic [1:0]                 operation_i    = '0;
  logic [SampleW-1:0]         sample_i       = '0;
  logic                       display_mode_i = 1'b0;
  logic                       out_ready_i    = 1'b0;
  logic                       cfg_ready_o;
  logic                       in_ready_o;
  logic                       out_valid_o;
  logic signed [TempW-1:0]    temp_c_o;
  logic                       peak_hold_o;
  logic                       fahrenheit_o;
  logic                       shown_mode_o;

  int   fail_count;
  int   pending;
  int   checked;
  int   n_samples  = 0;
  int   n_ticks    = 0;
  int   n_displays = 0;
  int   n_unused   = 0;
  int   n_cfg      = 0;
  int   ready_hold = 0;
  int   ready_pick;
  bit   idle_on    = 1'b1;
  logic tb_mode    = 1'b0;
  logic cur_long   = 1'b0;

  thermistor_average_peak_hold_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .sample_i       (sample_i),
    .display_mode_i (display_mode_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .temp_c_o       (temp_c_o),
    .peak_hold_o    (peak_hold_o),
    .fahrenheit_o   (fahrenheit_o),
    .shown_mode_o   (shown_mode_o)
  );

  temp_reading_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .operation_i    (operation_i),
    .sample_i       (sample_i),
    .display_mode_i (display_mode_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .temp_c_i       (temp_c_o),
    .peak_hold_i    (peak_hold_o),
    .fahrenheit_i   (fahrenheit_o),
    .shown_mode_i   (shown_mode_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Reading side: mostly short stalls, some long ones, runs of steady ready.
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 55) begin
        out_ready_i <= 1'b1;
        ready_hold = $urandom_range(0, 30);
      end else if (ready_pick < 90) begin
        out_ready_i <= 1'b0;
        ready_hold = $urandom_range(0, 3);
      end else begin
        out_ready_i <= 1'b0;
        ready_hold = $urandom_range(8, 60);
      end
    end
  end

  function automatic int input_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_item(logic [1:0] op, logic [9:0] smp, logic mode);
    int gap;
    gap = input_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    sample_i       <= smp;
    display_mode_i <= mode;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    case (op)
      OP_SAMPLE: n_samples++;
      OP_TICK:   n_ticks++;
      OP_DISPLAY: begin
        n_displays++;
        tb_mode = mode;
      end
      default:   n_unused++;
    endcase
  endtask

  // Drop valid and wait until every owed reading has been taken.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(logic fahr, logic long_hold);
    // age the peak past the short limit before lowering it
    if (cur_long && !long_hold) begin
      repeat (30) send_item(OP_TICK, 10'($urandom), 1'($urandom));
    end
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_FAHRENHEIT;
    cfg_data_i  <= fahr;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CFG_LONG_HOLD;
    cfg_data_i  <= long_hold;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_long = long_hold;
    n_cfg++;
  endtask

  // Send n samples of one flavor, mixed with ticks, readings and junk ops.
  task automatic fill_block(int n, int style);
    int         level;
    int         done;
    int         r;
    logic [9:0] smp;
    level = $urandom_range(20, 1003);
    done  = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_item(OP_TICK, 10'($urandom), 1'($urandom));
      end else if (r < 14) begin
        send_item(OP_DISPLAY, 10'($urandom), tb_mode);
      end else if (r < 16) begin
        send_item(OpUnused, 10'($urandom), 1'($urandom));
      end else begin
        case (style)
          0:       smp = 10'($urandom_range(0, 1023));
          1:       smp = 10'($urandom_range(768, 1023));
          2:       smp = 10'($urandom_range(0, 255));
          3:       smp = 10'($urandom_range(level - 20, level + 20));
          default: smp = 10'd1023;
        endcase
        send_item(OP_SAMPLE, smp, 1'($urandom));
        done++;
      end
    end
  endtask

  initial begin
    int base;
    int next_cfg;
    int phase;
    int kind;
    int d;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(1'b1, 1'b0);

    // Directed: empty readings in both modes, field extremes, junk op.
    send_item(OP_DISPLAY, 10'd0, 1'b0);
    send_item(OP_SAMPLE, 10'd0, 1'b0);
    send_item(OP_SAMPLE, 10'd1023, 1'b1);
    send_item(OP_SAMPLE, 10'h2AA, 1'b0);
    send_item(OP_SAMPLE, 10'h155, 1'b1);
    send_item(OP_TICK, 10'h3FF, 1'b1);
    send_item(OpUnused, 10'h3FF, 1'b1);
    send_item(OP_DISPLAY, 10'h3FF, 1'b1);
    send_item(OP_DISPLAY, 10'd0, 1'b1);
    send_item(OP_TICK, 10'd0, 1'b0);
    send_item(OP_TICK, 10'h2AA, 1'b1);
    send_item(OP_DISPLAY, 10'h155, 1'b0);
    send_item(OP_DISPLAY, 10'd0, 1'b0);

    // One full instant block summing to 65536: at peak scale the
    // resistance divisor becomes zero.
    for (int i = 0; i < 256; i++) begin
      d = $urandom_range(0, 127);
      send_item(OP_SAMPLE, 10'(128 + d), 1'($urandom));
      send_item(OP_SAMPLE, 10'(128 - d), 1'($urandom));
      if ($urandom_range(0, 19) == 0) send_item(OP_DISPLAY, 10'($urandom), 1'b0);
    end
    send_item(OP_DISPLAY, 10'($urandom), 1'b0);
    send_item(OP_DISPLAY, 10'($urandom), 1'b1);
    send_item(OP_DISPLAY, 10'($urandom), 1'b1);

    base     = n_samples + n_ticks + n_displays;
    next_cfg = 24;
    phase    = 0;
    while (n_samples + n_ticks + n_displays - base < 120) begin
      idle_on = ($urandom_range(0, 4) != 0);
      if (n_samples + n_ticks + n_displays - base >= next_cfg) begin
        case (phase % 5)
          0:       configure(1'b0, 1'b1);
          1:       configure(1'b1, 1'b1);
          2:       configure(1'b1, 1'b0);
          3:       configure(1'b0, 1'b0);
          default: configure(1'($urandom), 1'($urandom));
        endcase
        phase++;
        next_cfg += 24;
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        if (tb_mode != 1'b1) send_item(OP_DISPLAY, 10'($urandom), 1'b1);
        fill_block(64, $urandom_range(0, 4));
        send_item(OP_DISPLAY, 10'($urandom), 1'b1);
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 45)) send_item(OP_TICK, 10'($urandom), 1'($urandom));
        end
      end else if (kind < 85) begin
        if (tb_mode != 1'b0) send_item(OP_DISPLAY, 10'($urandom), 1'b0);
        fill_block($urandom_range(4, 40), $urandom_range(0, 3));
        send_item(OP_DISPLAY, 10'($urandom), 1'b0);
      end else begin
        // noise: any op, any mode, including stray mode switches
        repeat ($urandom_range(1, 8)) begin
          send_item(2'($urandom), 10'($urandom), 1'($urandom));
        end
      end
    end

    settle();
    repeat (150) @(posedge clk_i);

    $display("Run covered %0d samples, %0d ticks, %0d display requests, %0d unused ops",
             n_samples, n_ticks, n_displays, n_unused);
    $display("%0d readings checked across %0d register settings", checked, n_cfg);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Timeout guard that ends the run as failed.
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/taph_pkg.sv
hw/rtl/thermistor_average_peak_hold_core.sv
hw/rtl/taph_checker.sv
test/temp_reading_checker.sv
test/tb.sv
